// ----- rtl/core/mpi_pkg.sv -----
`timescale 1ns / 1ps

package mpi_pkg;

    // field widths
    localparam int OP_W   = 1;
    localparam int BASE_W = 32;
    localparam int EXP_W  = 63;
    localparam int RES_W  = 30;

    // exponent bit counter, wide enough to index the exponent
    localparam int CNT_W = $clog2(EXP_W);

    // prime modulus and the fixed inverse exponent
    localparam logic [RES_W-1:0] MODULUS = 30'd1000000007;
    localparam logic [EXP_W-1:0] INV_EXP = EXP_W'(64'd1000000007 - 64'd2);

    // barrett constant floor(2^60 / modulus), 31 bits
    localparam logic [63:0] MU_FULL = 64'h1000_0000_0000_0000 / 64'd1000000007;
    localparam logic [30:0] MU = MU_FULL[30:0];

    // operation codes
    localparam logic [OP_W-1:0] OP_POW = 1'b0;
    localparam logic [OP_W-1:0] OP_INV = 1'b1;

    // request to the shared modular multiplier
    typedef struct packed {
        logic              valid;
        logic [BASE_W-1:0] a;
        logic [RES_W-1:0]  b;
    } mpi_mul_req_t;

    // answer from the shared modular multiplier
    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] r;
    } mpi_mul_rsp_t;

endpackage

// ----- rtl/core/modular_power_and_inverse.sv -----
`timescale 1ns / 1ps

// channel   | valid   | ready   | payload
// ----------+---------+---------+---------------------------------
// input     | s_valid | s_ready | s_op, s_base, s_exponent
// result    | m_valid | m_ready | m_result
//
// one item at a time; each modular multiply runs on the single shared 32x32
// multiplier as product, barrett quotient, quotient times modulus, subtract
// and correct. an item is a base reduction, then a scan of the exponent from
// the msb, with a square and, for a set bit, a multiply for each bit after
// the top set bit; an inverse uses the fixed exponent modulus - 2.
// aresetn is synchronous and active low and clears the sequencers and valids.
// a stalled result holds in the output register while the next request is taken.

module modular_power_and_inverse
    import mpi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_op,
    input  logic [BASE_W-1:0] s_base,
    input  logic [EXP_W-1:0]  s_exponent,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [RES_W-1:0]  m_result
);

    typedef enum logic [2:0] {
        T_IDLE,
        T_RED,
        T_SCAN,
        T_SQR,
        T_MUL,
        T_DONE
    } tstate_t;

    tstate_t           state_reg;
    logic [EXP_W-1:0]  exp_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              started_reg;
    logic [RES_W-1:0]  acc_reg;
    logic [RES_W-1:0]  base_reg;
    logic              m_valid_reg;
    logic [RES_W-1:0]  m_result_reg;

    mpi_mul_req_t      req;
    mpi_mul_rsp_t      rsp;
    logic              accept;
    logic              top_bit;
    logic              last_bit;

    assign s_ready  = (state_reg == T_IDLE);
    assign accept   = s_valid && s_ready;
    assign top_bit  = exp_reg[EXP_W-1];
    assign last_bit = (cnt_reg == '0);

    // requests to the shared multiplier
    always_comb begin
        req.valid = 1'b0;
        req.a     = {{(BASE_W-RES_W){1'b0}}, acc_reg};
        req.b     = acc_reg;
        unique case (state_reg)
            T_IDLE: begin
                // reduce the base by multiplying with one
                req.valid = s_valid;
                req.a     = s_base;
                req.b     = RES_W'(1);
            end
            T_SCAN: begin
                req.valid = started_reg;
            end
            T_SQR: begin
                req.valid = rsp.done && top_bit;
                req.a     = {{(BASE_W-RES_W){1'b0}}, rsp.r};
                req.b     = base_reg;
            end
            T_RED, T_MUL, T_DONE: begin
                req.valid = 1'b0;
            end
            default: begin
                req.valid = 1'b0;
            end
        endcase
    end

    mpi_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    // square and multiply sequencer, msb first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            m_valid_reg <= 1'b0;
            started_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != T_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE: begin
                    if (accept) begin
                        exp_reg     <= (s_op == OP_INV) ? INV_EXP : s_exponent;
                        cnt_reg     <= CNT_W'(EXP_W - 1);
                        started_reg <= 1'b0;
                        acc_reg     <= RES_W'(1);
                        state_reg   <= T_RED;
                    end
                end
                T_RED: begin
                    if (rsp.done) begin
                        base_reg  <= rsp.r;
                        state_reg <= T_SCAN;
                    end
                end
                T_SCAN: begin
                    if (started_reg) begin
                        state_reg <= T_SQR;
                    end else begin
                        // leading zeros leave the accumulator at one
                        if (top_bit) begin
                            acc_reg     <= base_reg;
                            started_reg <= 1'b1;
                        end
                        if (last_bit) begin
                            state_reg <= T_DONE;
                        end else begin
                            exp_reg   <= exp_reg << 1;
                            cnt_reg   <= cnt_reg - 1'b1;
                            state_reg <= T_SCAN;
                        end
                    end
                end
                T_SQR: begin
                    if (rsp.done) begin
                        acc_reg <= rsp.r;
                        if (top_bit) begin
                            state_reg <= T_MUL;
                        end else if (last_bit) begin
                            state_reg <= T_DONE;
                        end else begin
                            exp_reg   <= exp_reg << 1;
                            cnt_reg   <= cnt_reg - 1'b1;
                            state_reg <= T_SCAN;
                        end
                    end
                end
                T_MUL: begin
                    if (rsp.done) begin
                        acc_reg <= rsp.r;
                        if (last_bit) begin
                            state_reg <= T_DONE;
                        end else begin
                            exp_reg   <= exp_reg << 1;
                            cnt_reg   <= cnt_reg - 1'b1;
                            state_reg <= T_SCAN;
                        end
                    end
                end
                T_DONE: begin
                    // wait for the output register to free up
                    if (!m_valid_reg || m_ready) begin
                        m_result_reg <= acc_reg;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= T_IDLE;
                    end
                end
                default: begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    // checks
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("second request taken while busy");

    a_start_state: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == T_RED) && (acc_reg == RES_W'(1)) && !started_reg)
        else $error("sequencer not primed after request");

    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_result_reg < MODULUS))
        else $error("result not reduced");

endmodule

// ----- rtl/core/mpi_modmul.sv -----
`timescale 1ns / 1ps

module mpi_modmul
    import mpi_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  mpi_mul_req_t req,
    output mpi_mul_rsp_t rsp
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_MUL,
        M_QUO,
        M_SUB,
        M_FIX
    } mstate_t;

    localparam logic [31:0] P32  = {2'b00, MODULUS};
    localparam logic [31:0] P2X  = {1'b0, MODULUS, 1'b0};

    mstate_t           state_reg;
    logic [31:0]       op_a_reg;
    logic [31:0]       op_b_reg;
    logic [59:0]       x_reg;
    logic [31:0]       r_reg;
    logic [RES_W-1:0]  res_reg;
    logic              done_reg;

    logic [63:0]       mul_out;
    logic [31:0]       r_m1;
    logic [31:0]       r_m2;
    logic [RES_W-1:0]  fixed;

    // the one shared 32x32 multiplier
    assign mul_out = {32'b0, op_a_reg} * {32'b0, op_b_reg};

    // final correction, barrett remainder is below three times the modulus
    assign r_m1 = r_reg - P32;
    assign r_m2 = r_reg - P2X;
    always_comb begin
        if (r_reg >= P2X) begin
            fixed = r_m2[RES_W-1:0];
        end else if (r_reg >= P32) begin
            fixed = r_m1[RES_W-1:0];
        end else begin
            fixed = r_reg[RES_W-1:0];
        end
    end

    // sequencer: product, quotient estimate, quotient times modulus, subtract, correct
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE: begin
                    if (req.valid) begin
                        op_a_reg  <= req.a;
                        op_b_reg  <= {2'b00, req.b};
                        state_reg <= M_MUL;
                    end
                end
                M_MUL: begin
                    x_reg     <= mul_out[59:0];
                    op_a_reg  <= {1'b0, mul_out[59:29]};
                    op_b_reg  <= {1'b0, MU};
                    state_reg <= M_QUO;
                end
                M_QUO: begin
                    op_a_reg  <= {1'b0, mul_out[61:31]};
                    op_b_reg  <= P32;
                    state_reg <= M_SUB;
                end
                M_SUB: begin
                    r_reg     <= x_reg[31:0] - mul_out[31:0];
                    state_reg <= M_FIX;
                end
                M_FIX: begin
                    res_reg   <= fixed;
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default: begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.r    = res_reg;

    // checks
    a_res_range: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (res_reg < MODULUS))
        else $error("modular product out of range");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("done held for more than one cycle");

    a_req_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.valid |-> (state_reg == M_IDLE))
        else $error("multiply requested while unit busy");

endmodule
